// ----- rtl/core/integer_array_sorter_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the sorter RTL.
// ----------------------------------------------------------------------------
`ifndef INTEGER_ARRAY_SORTER_UNIT_DEFINES_SVH
`define INTEGER_ARRAY_SORTER_UNIT_DEFINES_SVH

// checked on every edge outside reset
`define IAS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// checked on every edge, reset included
`define IAS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ----- rtl/core/ias_pkg.sv -----
// ----------------------------------------------------------------------------
// Sorter package
// Word types and control structs shared across the sorter.
// ----------------------------------------------------------------------------
package ias_pkg;

  localparam int unsigned DATA_W = 32;

  typedef logic signed [DATA_W-1:0] data_t;

  typedef struct packed {
    data_t value;
    logic  last_in;
  } in_word_t;

  typedef struct packed {
    data_t sorted_value;
    logic  last_out;
    logic  overflow;
  } out_word_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

endpackage

// ----- rtl/core/ias_stream_if.sv -----
// ----------------------------------------------------------------------------
// Stream interface
// Valid/ready channel carrying one word of a given type.
// ----------------------------------------------------------------------------
interface ias_stream_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/integer_array_sorter_unit.sv -----
// ----------------------------------------------------------------------------
// Integer array sorter
// Sorts a set of signed 32-bit words in ascending order.
// ----------------------------------------------------------------------------
// Words of a set are taken one per cycle while loading and dropped into a
// row of MAX_ENTRIES cells that always holds them in ascending order; each
// cell compares against the incoming word and either keeps its value, takes
// its left neighbor's, or takes the new word. The word flagged last closes
// the set. The set is then shifted out of the first cell one word per cycle
// while the output is ready, with the input held off until the set is out.
// Words past capacity are discarded and every output word of that set has
// overflow set.
module integer_array_sorter_unit #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic         clk,
  input  logic         rst,
  ias_stream_if.sink   elements,
  ias_stream_if.source results
);

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  ias_pkg::in_word_t   in_word;
  ias_pkg::out_word_t  out_word;
  ias_pkg::cell_ctrl_t ctrl;
  logic [CNT_W-1:0]    count;
  logic                out_last;
  logic                overflow;

  logic           gt    [MAX_ENTRIES];
  ias_pkg::data_t value [MAX_ENTRIES];

  assign in_word = elements.data;

  ias_ctrl #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .CNT_W      (CNT_W)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (elements.valid),
    .in_last  (in_word.last_in),
    .in_ready (elements.ready),
    .out_valid(results.valid),
    .out_ready(results.ready),
    .out_last (out_last),
    .overflow (overflow),
    .count    (count),
    .ctrl     (ctrl)
  );

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic           occ;
    logic           prev_gt;
    ias_pkg::data_t prev_value;
    ias_pkg::data_t next_value;

    assign occ = (count > CNT_W'(i));

    if (i == 0) begin : g_head
      assign prev_gt    = 1'b0;
      assign prev_value = '0;
    end else begin : g_body
      assign prev_gt    = gt[i-1];
      assign prev_value = value[i-1];
    end

    if (i == MAX_ENTRIES - 1) begin : g_tail
      assign next_value = '0;
    end else begin : g_link
      assign next_value = value[i+1];
    end

    ias_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .x         (in_word.value),
      .occ       (occ),
      .prev_gt   (prev_gt),
      .prev_value(prev_value),
      .next_value(next_value),
      .gt        (gt[i]),
      .value     (value[i])
    );
  end

  assign out_word.sorted_value = value[0];
  assign out_word.last_out     = out_last;
  assign out_word.overflow     = overflow;
  assign results.data          = out_word;

endmodule

// ----- rtl/core/ias_cell.sv -----
// ----------------------------------------------------------------------------
// Sorter cell
// One slot of the insertion chain: keeps, takes the left neighbor or the new
// word on insert, and takes the right neighbor on unload.
// ----------------------------------------------------------------------------
module ias_cell (
  input  logic               clk,
  input  ias_pkg::cell_ctrl_t ctrl,
  input  ias_pkg::data_t     x,
  input  logic               occ,
  input  logic               prev_gt,
  input  ias_pkg::data_t     prev_value,
  input  ias_pkg::data_t     next_value,
  output logic               gt,
  output ias_pkg::data_t     value
);

  // empty slot counts as larger than anything
  assign gt = !occ || (value > x);

  always_ff @(posedge clk) begin
    if (ctrl.insert && gt) begin
      value <= prev_gt ? prev_value : x;
    end else if (ctrl.shift) begin
      value <= next_value;
    end
  end

endmodule

// ----- rtl/core/ias_ctrl.sv -----
// ----------------------------------------------------------------------------
// Sorter control
// Load/unload sequencing, fill count and overflow flag.
// ----------------------------------------------------------------------------
`include "integer_array_sorter_unit_defines.svh"

module ias_ctrl #(
  parameter int MAX_ENTRIES = 64,
  parameter int CNT_W       = 7
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_last,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_last,
  output logic                overflow,
  output logic [CNT_W-1:0]    count,
  output ias_pkg::cell_ctrl_t ctrl
);

  localparam logic STATE_LOAD   = 1'b0;
  localparam logic STATE_UNLOAD = 1'b1;
  localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_ENTRIES);
  localparam logic [CNT_W-1:0] ONE  = CNT_W'(1);

  logic state;
  logic dropped;
  logic in_fire;
  logic out_fire;
  logic full;

  assign full      = (count == FULL);
  assign in_ready  = (state == STATE_LOAD);
  assign out_valid = (state == STATE_UNLOAD);
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;
  assign out_last  = (count == ONE);
  assign overflow  = dropped;

  assign ctrl.insert = in_fire && !full;
  assign ctrl.shift  = out_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= STATE_LOAD;
      count   <= '0;
      dropped <= 1'b0;
    end else begin
      case (state)
        STATE_LOAD: begin
          if (in_fire) begin
            if (full) begin
              dropped <= 1'b1;
            end else begin
              count <= count + ONE;
            end
            if (in_last) begin
              state <= STATE_UNLOAD;
            end
          end
        end
        STATE_UNLOAD: begin
          if (out_fire) begin
            count <= count - ONE;
            if (out_last) begin
              state   <= STATE_LOAD;
              dropped <= 1'b0;
            end
          end
        end
        default: begin
          state <= STATE_LOAD;
        end
      endcase
    end
  end

  `IAS_ASSERT(a_count_cap, clk, rst, (count <= FULL), "fill count above capacity")
  `IAS_ASSERT(a_unload_nonempty, clk, rst, (out_valid |-> count != '0), "empty set emitted")
  `IAS_ASSERT(a_close_unloads, clk, rst, (in_fire && in_last |=> out_valid), "set not closed")
  `IAS_ASSERT(a_drain_step, clk, rst, (out_fire && !out_last |=> out_valid && count == $past(count) - ONE), "bad drain")
  `IAS_ASSERT_ALWAYS(a_reset_clear, clk, (rst |=> count == '0 && !dropped && in_ready), "reset state")

endmodule

// ----- tb/integer_array_sorter_unit_tb.sv -----
// ----------------------------------------------------------------------------
// Integer array sorter testbench
// Streams sets of signed words into the sorter and checks each sorted word
// against a behavioral insertion sort kept alongside. Covers extremes, sign
// ordering, duplicates, full and overflowing sets, random gaps on both sides
// and one long output back-pressure stretch.
// ----------------------------------------------------------------------------
module integer_array_sorter_unit_tb;

  localparam int CAPACITY = 64;
  localparam int TOTAL_ITEMS = 360;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_AT = 40;
  localparam int HOLD_CYCLES = 400;
  localparam ias_pkg::data_t MIN_VAL = {1'b1, {31{1'b0}}};
  localparam ias_pkg::data_t MAX_VAL = {1'b0, {31{1'b1}}};

  typedef struct {
    ias_pkg::in_word_t word;
    int unsigned       gap;
  } feed_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ias_stream_if #(.word_t(ias_pkg::in_word_t))  elem_bus ();
  ias_stream_if #(.word_t(ias_pkg::out_word_t)) sort_bus ();

  integer_array_sorter_unit #(
    .MAX_ENTRIES(CAPACITY)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .elements (elem_bus),
    .results  (sort_bus)
  );

  always #5 clk = ~clk;

  feed_item_t         feed_q[$];
  ias_pkg::data_t     open_set[$];
  bit                 set_dropped = 1'b0;
  ias_pkg::out_word_t sorted_due[$];
  int unsigned        error_count = 0;
  int unsigned        words_seen = 0;
  int unsigned        cycle_count = 0;

  // insertion sort of the open set; closing word releases the whole set
  task automatic absorb_element(input ias_pkg::in_word_t w);
    int unsigned        pos;
    ias_pkg::out_word_t o;
    if (open_set.size() < CAPACITY) begin
      pos = open_set.size();
      while (pos > 0 && $signed(open_set[pos-1]) > $signed(w.value)) pos--;
      open_set.insert(pos, w.value);
    end else begin
      set_dropped = 1'b1;
    end
    if (w.last_in) begin
      foreach (open_set[k]) begin
        o.sorted_value = open_set[k];
        o.last_out     = (k == open_set.size() - 1);
        o.overflow     = set_dropped;
        sorted_due.push_back(o);
      end
      open_set.delete();
      set_dropped = 1'b0;
    end
  endtask

  task automatic add_elem(input ias_pkg::data_t v, input bit last, input int unsigned gap);
    feed_item_t it;
    it.word.value   = v;
    it.word.last_in = last;
    it.gap          = gap;
    feed_q.push_back(it);
  endtask

  function automatic ias_pkg::data_t pick_value();
    ias_pkg::data_t v;
    case ($urandom_range(0, 2))
      0: v = $urandom;
      1: v = $signed($urandom_range(0, 8)) - 4;
      default: begin
        case ($urandom_range(0, 3))
          0: v = MIN_VAL;
          1: v = MAX_VAL;
          2: v = '0;
          default: v = '1;
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic add_random_set(input int unsigned n);
    bit calm;
    calm = ($urandom_range(0, 3) == 0);
    for (int unsigned i = 0; i < n; i++)
      add_elem(pick_value(), i == n - 1, calm ? 0 : $urandom_range(0, 10));
  endtask

  function automatic int unsigned rgap();
    return $urandom_range(0, 10);
  endfunction

  // word source
  int unsigned idle_cnt;
  always @(posedge clk) begin : drive
    feed_item_t it;
    if (rst) begin
      elem_bus.valid <= 1'b0;
      elem_bus.data  <= '0;
      idle_cnt       <= 0;
    end else begin
      if (elem_bus.valid && elem_bus.ready) absorb_element(elem_bus.data);
      if (!elem_bus.valid || elem_bus.ready) begin
        if (feed_q.size() > 0 && idle_cnt >= feed_q[0].gap) begin
          it = feed_q.pop_front();
          elem_bus.data  <= it.word;
          elem_bus.valid <= 1'b1;
          idle_cnt       <= 0;
        end else begin
          elem_bus.valid <= 1'b0;
          idle_cnt       <= idle_cnt + 1;
        end
      end
    end
  end

  // result sink and checker
  int unsigned stall_cnt, stall_goal, long_hold;
  bit          calm_out;
  always @(posedge clk) begin : monitor
    bit                 took;
    int unsigned        goal;
    ias_pkg::out_word_t got, exp;
    if (rst) begin
      sort_bus.ready <= 1'b0;
      stall_cnt      <= 0;
      stall_goal     <= 0;
      long_hold      <= 0;
      calm_out       <= 1'b0;
    end else begin
      took = sort_bus.valid && sort_bus.ready;
      if (took) begin
        got = sort_bus.data;
        words_seen++;
        if (sorted_due.size() == 0) begin
          error_count++;
          $display("%0t unexpected word: expected none, got %0d", $time, got.sorted_value);
        end else begin
          exp = sorted_due.pop_front();
          if (got.sorted_value !== exp.sorted_value) begin
            error_count++;
            $display("%0t sorted_value: expected %0d, got %0d", $time,
                     exp.sorted_value, got.sorted_value);
          end
          if (got.last_out !== exp.last_out) begin
            error_count++;
            $display("%0t last_out: expected %0b, got %0b", $time,
                     exp.last_out, got.last_out);
          end
          if (got.overflow !== exp.overflow) begin
            error_count++;
            $display("%0t overflow: expected %0b, got %0b", $time,
                     exp.overflow, got.overflow);
          end
        end
        if (got.last_out) calm_out <= ($urandom_range(0, 3) == 0);
      end
      if (took && words_seen == HOLD_AT) begin
        long_hold      <= HOLD_CYCLES;
        sort_bus.ready <= 1'b0;
      end else if (long_hold != 0) begin
        long_hold      <= long_hold - 1;
        sort_bus.ready <= 1'b0;
      end else if (took) begin
        goal = calm_out ? 0 : $urandom_range(0, 10);
        stall_goal     <= goal;
        stall_cnt      <= 0;
        sort_bus.ready <= (goal == 0);
      end else if (!sort_bus.ready) begin
        if (stall_cnt >= stall_goal) sort_bus.ready <= 1'b1;
        else stall_cnt <= stall_cnt + 1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int unsigned set_idx, n, r;

    // single-word sets at both extremes
    add_elem(MIN_VAL, 1'b1, rgap());
    add_elem(MAX_VAL, 1'b1, rgap());
    // duplicates
    add_elem(32'sd5, 1'b0, 0);
    add_elem(32'sd5, 1'b0, 0);
    add_elem(32'sd5, 1'b1, 0);
    // descending input
    add_elem(MAX_VAL, 1'b0, rgap());
    add_elem(32'sd1, 1'b0, rgap());
    add_elem(32'sd0, 1'b0, rgap());
    add_elem(-32'sd1, 1'b0, rgap());
    add_elem(MIN_VAL, 1'b1, rgap());
    // ascending input
    add_elem(MIN_VAL, 1'b0, 0);
    add_elem(-32'sd1, 1'b0, 0);
    add_elem(32'sd0, 1'b0, 0);
    add_elem(32'sd1, 1'b0, 0);
    add_elem(MAX_VAL, 1'b1, 0);
    // sign bit decides order
    add_elem(32'h7FFF_FFFF, 1'b0, rgap());
    add_elem(32'h8000_0000, 1'b0, rgap());
    add_elem(32'h5555_5555, 1'b0, rgap());
    add_elem(32'hAAAA_AAAA, 1'b1, rgap());

    set_idx = 0;
    while (feed_q.size() < TOTAL_ITEMS) begin
      r = $urandom_range(0, 19);
      if (set_idx == 2) n = CAPACITY + 2;
      else if (set_idx == 5) n = CAPACITY + 1;
      else if (set_idx == 8) n = CAPACITY;
      else if (r < 15) n = $urandom_range(1, 10);
      else if (r < 17) n = $urandom_range(CAPACITY - 4, CAPACITY);
      else n = $urandom_range(CAPACITY + 1, CAPACITY + 8);
      if (n > TOTAL_ITEMS - feed_q.size()) n = TOTAL_ITEMS - feed_q.size();
      add_random_set(n);
      set_idx++;
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (feed_q.size() != 0 || elem_bus.valid) @(posedge clk);
    while (sorted_due.size() != 0) @(posedge clk);
    repeat (2 * CAPACITY + 20) @(posedge clk);

    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
